[rtl/core/sdwq_pkg.sv]
// Shared types and constants for the slot deadline window queue.
package sdwq_pkg;

    localparam logic       REQ_ADD     = 1'b0;
    localparam logic       REQ_TAKE    = 1'b1;
    localparam logic       ST_OK       = 1'b0;
    localparam logic       ST_OVERRUN  = 1'b1;
    localparam logic [63:0] SLOT_NONE  = {64{1'b1}};

    typedef struct packed {
        logic               req_type;
        logic [63:0]        slot;
        logic [62:0]        delay;
        logic signed [63:0] now;
        logic [63:0]        retire_slot;
        logic [63:0]        scan_from;
    } t_req;

    typedef struct packed {
        logic        due_found;
        logic [63:0] due_slot;
        logic        status;
        logic [63:0] window_first;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_FILL,
        S_RMW,
        S_SCAN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        ADD_REJECT,
        ADD_EMPTY,
        ADD_BELOW,
        ADD_ABOVE,
        ADD_INSIDE
    } t_add_kind;

    typedef struct packed {
        logic load;
        logic decide;
        logic fill;
        logic rmw;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic      is_take;
        t_add_kind kind;
        logic      fill_done;
        logic      scan_done;
        logic      out_free;
    } t_sts;

endpackage

[rtl/core/sdwq_chan_if.sv]
// Valid/ready channel interface carrying one payload beat.
interface sdwq_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/sdwq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sdwq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/sdwq_ctrl.sv]
// Sequencer for the slot deadline window queue.
module sdwq_ctrl
    import sdwq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.is_take) begin
                    n_state = S_SCAN;
                end else begin
                    case (i_sts.kind)
                        ADD_BELOW, ADD_ABOVE: n_state = S_FILL;
                        ADD_INSIDE:           n_state = S_RMW;
                        default:              n_state = S_DONE;
                    endcase
                end
            end
            S_FILL: begin
                if (i_sts.fill_done) begin
                    n_state = S_DONE;
                end
            end
            S_RMW: begin
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECIDE: o_cmd.decide = 1'b1;
            S_FILL:   o_cmd.fill   = !i_sts.fill_done;
            S_RMW:    o_cmd.rmw    = 1'b1;
            S_SCAN:   o_cmd.scan   = 1'b1;
            S_DONE:   o_cmd.finish = i_sts.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end
endmodule

[rtl/core/sdwq_dp.sv]
// Datapath: window bounds, deadline ring, fill and scan cursors, result register.
module sdwq_dp
    import sdwq_pkg::*;
#(
    parameter int RING_DEPTH = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  t_req i_req,
    output t_rsp o_rsp,
    output logic o_out_valid,
    input  logic i_out_ready
);
    localparam int          RING_AW = $clog2(RING_DEPTH);
    localparam logic [63:0] DEPTH64 = 64'(RING_DEPTH);

    t_req        r_req;
    logic [63:0] r_when;
    logic [63:0] r_start;
    logic [63:0] r_end;
    logic [63:0] r_idx;
    logic [63:0] r_fill_end;
    logic [63:0] r_eval_idx;
    logic        r_pend;
    logic        r_found;
    logic [63:0] r_due;
    logic        r_status;
    t_rsp        r_out;
    logic        r_out_valid;

    t_add_kind    kind;
    logic         is_take;
    logic         issue;
    logic         skip;
    logic         hit;
    logic         keep_old;
    logic [63:0]  take_first;
    logic [63:0]  q;
    logic         we;
    logic [RING_AW-1:0] waddr;
    logic [63:0]  wdata;
    logic [RING_AW-1:0] raddr;

    sdwq_ram #(
        .WIDTH (64),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    // Classify an add against the current window.
    always_comb begin
        if (r_req.slot == SLOT_NONE) begin
            kind = ADD_REJECT;
        end else if (r_start == r_end) begin
            kind = ADD_EMPTY;
        end else if (r_req.slot < r_start) begin
            kind = ((r_end - r_req.slot) > DEPTH64) ? ADD_REJECT : ADD_BELOW;
        end else if (r_req.slot >= r_end) begin
            kind = ((r_req.slot + 64'd1 - r_start) > DEPTH64) ? ADD_REJECT : ADD_ABOVE;
        end else begin
            kind = ADD_INSIDE;
        end
    end

    assign is_take    = (r_req.req_type == REQ_TAKE);
    assign take_first = (r_req.scan_from > r_start) ? r_req.scan_from : r_start;
    assign issue      = (r_idx < r_end);
    assign skip       = (r_eval_idx <= r_req.retire_slot) || (q == 64'd0);
    assign hit        = r_pend && !skip && ($signed(q) <= r_req.now);
    assign keep_old   = (q != 64'd0) && ($signed(q) <= $signed(r_when));

    assign o_sts.is_take   = is_take;
    assign o_sts.kind      = kind;
    assign o_sts.fill_done = (r_idx == r_fill_end);
    assign o_sts.scan_done = hit || (!r_pend && !issue);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Ring ports: one write and one read a cycle.
    always_comb begin
        we    = 1'b0;
        waddr = r_req.slot[RING_AW-1:0];
        wdata = r_when;
        raddr = r_idx[RING_AW-1:0];
        if (i_cmd.decide) begin
            raddr = r_req.slot[RING_AW-1:0];
            we    = !is_take && (kind == ADD_EMPTY || kind == ADD_BELOW ||
                                 kind == ADD_ABOVE);
        end else if (i_cmd.fill) begin
            we    = 1'b1;
            waddr = r_idx[RING_AW-1:0];
            wdata = 64'd0;
        end else if (i_cmd.rmw) begin
            we    = !keep_old;
        end else if (i_cmd.scan) begin
            we    = hit;
            waddr = r_eval_idx[RING_AW-1:0];
            wdata = 64'd0;
        end
    end

    // Control state: window bounds, scan pipeline flag, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= 64'd0;
            r_end       <= 64'd0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.decide && !is_take) begin
                case (kind)
                    ADD_EMPTY: begin
                        r_start <= r_req.slot;
                        r_end   <= r_req.slot + 64'd1;
                    end
                    ADD_BELOW: r_start <= r_req.slot;
                    ADD_ABOVE: r_end   <= r_req.slot + 64'd1;
                    default: ;
                endcase
            end
            if (i_cmd.scan) begin
                r_pend <= issue;
                // Pop a leading entry that is skipped or taken.
                if (r_pend && (skip || hit) && (r_eval_idx == r_start)) begin
                    r_start <= r_eval_idx + 64'd1;
                end
            end
        end
    end

    // Payload and cursors.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req;
            r_when   <= i_req.now + {1'b0, i_req.delay};
            r_found  <= 1'b0;
            r_due    <= SLOT_NONE;
            r_status <= ST_OK;
        end
        if (i_cmd.decide) begin
            if (is_take) begin
                r_idx <= take_first;
            end else begin
                case (kind)
                    ADD_REJECT: r_status <= ST_OVERRUN;
                    ADD_BELOW: begin
                        r_idx      <= r_req.slot + 64'd1;
                        r_fill_end <= r_start;
                    end
                    ADD_ABOVE: begin
                        r_idx      <= r_end;
                        r_fill_end <= r_req.slot;
                    end
                    default: ;
                endcase
            end
        end
        if (i_cmd.fill) begin
            r_idx <= r_idx + 64'd1;
        end
        if (i_cmd.scan) begin
            if (issue) begin
                r_eval_idx <= r_idx;
                r_idx      <= r_idx + 64'd1;
            end
            if (hit) begin
                r_found <= 1'b1;
                r_due   <= r_eval_idx;
            end
        end
        if (i_cmd.finish) begin
            r_out.due_found    <= r_found;
            r_out.due_slot     <= r_due;
            r_out.status       <= r_status;
            r_out.window_first <= r_start;
        end
    end

    assign o_rsp       = r_out;
    assign o_out_valid = r_out_valid;
endmodule

[rtl/core/slot_deadline_window_queue.sv]
// Top level of the slot deadline window queue: sequencer, datapath and checks.
//
// Keeps a window [start, end) of consecutive slot numbers mapped onto a ring
// of RING_DEPTH signed 64-bit deadlines, where zero marks an empty entry. An
// add beat (req_type 0) sets slot's deadline to now + delay: it opens the
// window on an empty queue, grows it down or up with the new entries zeroed,
// or tightens an existing entry in place; growth past RING_DEPTH slots, or
// the all-ones slot, is refused with status 1 and no state change. A take
// beat (req_type 1) walks from max(scan_from, start) toward end, skips empty
// entries and slots at or below retire_slot, returns and clears the first
// entry due at now, and pops leading skipped or taken entries. Each beat
// gives exactly one result beat carrying the window start after the beat.
// Timing: one beat is in work at a time. After accept, an add that opens
// the window or is refused goes through decide and done; one that tightens
// in place goes through decide, a read-modify-write step and done; one that
// grows the window goes through decide, a fill that zeroes each new entry,
// up to RING_DEPTH - 2 entries, and done. A take goes through decide, a scan
// that walks the ring entries from its start point toward end, and done.
// The single write port of the deadline RAM sets the fill rate and its
// registered read sets the one-entry-per-cycle walk of the scan. A finished
// result waits in the output register while the next beat is accepted and
// worked; that beat holds in its last cycle until the earlier result is
// taken. The ring needs no clearing pass after reset: every entry inside
// the window is written before it is read.
module slot_deadline_window_queue
    import sdwq_pkg::*;
#(
    parameter int RING_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdwq_chan_if.sink   i_req,
    sdwq_chan_if.source o_rsp
);
    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;
    t_rsp rsp;

    sdwq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sdwq_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_req.data),
        .o_rsp       (rsp),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = rsp;

    // Only one datapath operation per cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.decide, cmd.fill, cmd.rmw, cmd.scan, cmd.finish}))
        else $error("more than one datapath command active");

    // An accepted beat holds off the next one until it is finished.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && in_ready |=> !in_ready)
        else $error("input accepted while a beat is in work");

    // Finishing a beat always presents a result beat next cycle.
    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> out_valid)
        else $error("finished beat did not reach the output");

    // A found slot never comes with a refusal or the none marker.
    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && rsp.due_found |-> rsp.status == ST_OK && rsp.due_slot != SLOT_NONE)
        else $error("inconsistent take result");
endmodule

[tb/sv/tb_slot_deadline_window_queue.sv]
// Self-checking testbench for the slot deadline window queue.
module tb_slot_deadline_window_queue
    import sdwq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RING_DEPTH     = 1024;
    localparam int          RING_BITS      = $clog2(RING_DEPTH);
    localparam int          RANDOM_BEATS   = 800;
    localparam int          DRAIN_CYCLES   = RING_DEPTH + 80;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam logic [63:0] MAX_POS        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_NEG        = 64'h8000_0000_0000_0000;
    localparam logic [62:0] DELAY_MAX      = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp want;
    } t_dir_row;

    logic clk;
    logic rst_n;

    sdwq_chan_if #(.t_payload(t_req)) req_if ();
    sdwq_chan_if #(.t_payload(t_rsp)) rsp_if ();

    slot_deadline_window_queue #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Shadow copy of the window and the deadline ring.
    logic [63:0] win_lo;
    logic [63:0] win_hi;
    logic [63:0] ring_deadline [RING_DEPTH];

    t_rsp        pending_rsp [$];
    t_dir_row    dir_rows [$];
    int          error_count;
    int          idle_cycles;
    bit          calm;

    // 2 ns clock.
    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Apply one beat to the shadow window and return the result it gives.
    function automatic t_rsp window_step(input t_req r);
        t_rsp        res;
        logic [63:0] when;
        logic [63:0] s;
        logic [63:0] cur;
        bit          hit;
        res.due_found = 1'b0;
        res.due_slot  = SLOT_NONE;
        res.status    = ST_OK;
        if (r.req_type == REQ_ADD) begin
            // Deadline wraps modulo 2^64; a zero deadline reads as empty.
            when = r.now + {1'b0, r.delay};
            if (r.slot == SLOT_NONE) begin
                // Window end would not be representable: refuse.
                res.status = ST_OVERRUN;
            end else if (win_lo == win_hi) begin
                win_lo = r.slot;
                win_hi = r.slot + 64'd1;
                ring_deadline[r.slot[RING_BITS-1:0]] = when;
            end else if (r.slot < win_lo) begin
                if (win_hi - r.slot > 64'(RING_DEPTH)) begin
                    res.status = ST_OVERRUN;
                end else begin
                    ring_deadline[r.slot[RING_BITS-1:0]] = when;
                    for (s = r.slot + 64'd1; s < win_lo; s++)
                        ring_deadline[s[RING_BITS-1:0]] = '0;
                    win_lo = r.slot;
                end
            end else if (r.slot >= win_hi) begin
                if (r.slot + 64'd1 - win_lo > 64'(RING_DEPTH)) begin
                    res.status = ST_OVERRUN;
                end else begin
                    for (s = win_hi; s < r.slot; s++)
                        ring_deadline[s[RING_BITS-1:0]] = '0;
                    ring_deadline[r.slot[RING_BITS-1:0]] = when;
                    win_hi = r.slot + 64'd1;
                end
            end else begin
                // Tighten in place: take the new deadline if empty or earlier.
                cur = ring_deadline[r.slot[RING_BITS-1:0]];
                if (cur == '0 || $signed(cur) > $signed(when))
                    ring_deadline[r.slot[RING_BITS-1:0]] = when;
            end
        end else begin
            s   = (r.scan_from > win_lo) ? r.scan_from : win_lo;
            hit = 1'b0;
            while (!hit && s < win_hi) begin
                cur = ring_deadline[s[RING_BITS-1:0]];
                if (s <= r.retire_slot || cur == '0) begin
                    if (win_lo == s) win_lo = s + 64'd1;
                end else if ($signed(cur) <= $signed(r.now)) begin
                    ring_deadline[s[RING_BITS-1:0]] = '0;
                    if (win_lo == s) win_lo = s + 64'd1;
                    res.due_found = 1'b1;
                    res.due_slot  = s;
                    hit           = 1'b1;
                end
                s = s + 64'd1;
            end
        end
        res.window_first = win_lo;
        return res;
    endfunction

    task automatic put_row(input logic req_type, input logic [63:0] slot,
                           input logic [62:0] delay, input logic [63:0] now,
                           input logic [63:0] retire, input logic [63:0] scan,
                           input bit typed, input logic found,
                           input logic [63:0] due, input logic status,
                           input logic [63:0] first);
        t_dir_row row;
        row.req.req_type     = req_type;
        row.req.slot         = slot;
        row.req.delay        = delay;
        row.req.now          = now;
        row.req.retire_slot  = retire;
        row.req.scan_from    = scan;
        row.typed            = typed;
        row.want.due_found    = found;
        row.want.due_slot     = due;
        row.want.status       = status;
        row.want.window_first = first;
        dir_rows.push_back(row);
    endtask

    // Drive one request beat, hold it until accepted, then record what it owes.
    task automatic send_beat(input t_req r, input bit typed, input t_rsp want);
        t_rsp predicted;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 15) begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        // Advance the shadow state even where the answer is typed in.
        predicted = window_step(r);
        pending_rsp.push_back(typed ? want : predicted);
    endtask

    // Result side: stall at random, except during the calm stretch.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            rsp_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
        end
    end

    // Check every result beat against the oldest expectation, and watch for
    // a stuck handshake.
    always @(posedge clk) begin
        t_rsp got;
        t_rsp want;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got = rsp_if.data;
            if (pending_rsp.size() == 0) begin
                $error("unexpected result beat: window_first %0h", got.window_first);
                error_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (got.due_found !== want.due_found) begin
                    $error("due_found: expected %0d, got %0d",
                           want.due_found, got.due_found);
                    error_count++;
                end
                if (got.due_slot !== want.due_slot) begin
                    $error("due_slot: expected %0h, got %0h", want.due_slot, got.due_slot);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
                if (got.window_first !== want.window_first) begin
                    $error("window_first: expected %0h, got %0h",
                           want.window_first, got.window_first);
                    error_count++;
                end
            end
        end
        if ((rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
            (req_if.valid === 1'b1 && req_if.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[slot_deadline_window_queue] ERROR");
            $finish;
        end
    end

    initial begin
        t_req        r;
        t_rsp        none;
        logic [63:0] sim_now;
        int          pick;
        int          k;

        req_if.valid = 1'b0;
        req_if.data  = '0;
        rst_n        = 1'b0;
        calm         = 1'b0;
        error_count  = 0;
        idle_cycles  = 0;
        none         = '0;
        win_lo       = '0;
        win_hi       = '0;
        foreach (ring_deadline[i]) ring_deadline[i] = '0;

        // Directed table. Typed rows carry their answer; the rest go through
        // the shadow model.
        //      type      slot              delay      now      retire     scan
        put_row(REQ_TAKE, 64'd0,            63'd0,     64'd0,   64'd0,     64'd0,
                1, 1'b0, SLOT_NONE, ST_OK, 64'd0);          // take on empty window
        put_row(REQ_ADD,  SLOT_NONE,        63'd5,     64'd10,  64'd0,     64'd0,
                1, 1'b0, SLOT_NONE, ST_OVERRUN, 64'd0);     // all-ones slot refused
        put_row(REQ_ADD,  64'd100,          63'd5,     64'd10,  64'd0,     64'd0,
                1, 1'b0, SLOT_NONE, ST_OK, 64'd100);        // open window
        put_row(REQ_ADD,  64'd100,          63'd2,     64'd10,  64'd0,     64'd0,
                1, 1'b0, SLOT_NONE, ST_OK, 64'd100);        // tighten in place
        put_row(REQ_ADD,  64'd100,          63'd20,    64'd10,  64'd0,     64'd0,
                0, 1'b0, SLOT_NONE, ST_OK, 64'd0);          // earlier deadline kept
        put_row(REQ_ADD,  64'd1123,         63'd0,     64'd5,   64'd0,     64'd0,
                1, 1'b0, SLOT_NONE, ST_OK, 64'd100);        // grow up to full ring
        put_row(REQ_ADD,  64'd99,           63'd0,     64'd0,   64'd0,     64'd0,
                1, 1'b0, SLOT_NONE, ST_OVERRUN, 64'd100);   // grow down one too far
        put_row(REQ_ADD,  64'd1124,         63'd0,     64'd0,   64'd0,     64'd0,
                1, 1'b0, SLOT_NONE, ST_OVERRUN, 64'd100);   // grow up one too far
        put_row(REQ_TAKE, 64'd0,            63'd0,     64'd11,  64'd0,     64'd0,
                1, 1'b1, 64'd1123, ST_OK, 64'd100);         // walk the whole ring
        put_row(REQ_TAKE, 64'd0,            63'd0,     64'd12,  64'd0,     64'd0,
                1, 1'b1, 64'd100, ST_OK, 64'd101);          // take and pop the head
        put_row(REQ_TAKE, 64'd0,            63'd0,     MAX_POS, 64'd0,     64'd0,
                1, 1'b0, SLOT_NONE, ST_OK, 64'd1124);       // pop all empties
        put_row(REQ_ADD,  64'd5,            63'd1,     SLOT_NONE, 64'd0,   64'd0,
                1, 1'b0, SLOT_NONE, ST_OK, 64'd5);          // deadline wraps to zero
        put_row(REQ_TAKE, 64'd0,            63'd0,     MAX_POS, 64'd0,     64'd0,
                1, 1'b0, SLOT_NONE, ST_OK, 64'd6);          // zero deadline is empty
        put_row(REQ_ADD,  64'd6,            DELAY_MAX, MAX_POS, 64'd0,     64'd0,
                1, 1'b0, SLOT_NONE, ST_OK, 64'd6);          // largest delay and now
        put_row(REQ_ADD,  64'd10,           63'd0,     MIN_NEG, 64'd0,     64'd0,
                1, 1'b0, SLOT_NONE, ST_OK, 64'd6);          // most negative deadline
        put_row(REQ_TAKE, 64'd0,            63'd0,     MIN_NEG, 64'd6,     64'd0,
                1, 1'b1, 64'd10, ST_OK, 64'd11);            // retired head skipped
        put_row(REQ_ADD,  SLOT_NONE - 64'd1, 63'd3,    64'd0,   64'd0,     64'd0,
                1, 1'b0, SLOT_NONE, ST_OK, SLOT_NONE - 64'd1); // top usable slot
        put_row(REQ_TAKE, 64'd0,            63'd0,     64'd3,   64'd0,     SLOT_NONE,
                1, 1'b0, SLOT_NONE, ST_OK, SLOT_NONE - 64'd1); // scan starts past end
        put_row(REQ_TAKE, 64'd0,            63'd0,     64'd3,   64'd0,     64'd0,
                1, 1'b1, SLOT_NONE - 64'd1, ST_OK, SLOT_NONE);
        put_row(REQ_ADD,  SLOT_NONE,        63'd0,     64'd0,   64'd0,     64'd0,
                1, 1'b0, SLOT_NONE, ST_OVERRUN, SLOT_NONE);
        put_row(REQ_ADD,  64'd0,            63'd7,     64'd0,   64'd0,     64'd0,
                1, 1'b0, SLOT_NONE, ST_OK, 64'd0);
        put_row(REQ_ADD,  64'd3,            63'd1,     64'd0,   64'd0,     64'd0,
                0, 1'b0, SLOT_NONE, ST_OK, 64'd0);
        put_row(REQ_TAKE, 64'd0,            63'd0,     64'd0,   SLOT_NONE, 64'd0,
                1, 1'b0, SLOT_NONE, ST_OK, 64'd4);          // retire everything
        put_row(REQ_ADD,  64'd8,            63'd5,     64'd0,   64'd0,     64'd0,
                0, 1'b0, SLOT_NONE, ST_OK, 64'd0);
        put_row(REQ_ADD,  64'd2,            63'd4,     64'd0,   64'd0,     64'd0,
                0, 1'b0, SLOT_NONE, ST_OK, 64'd0);          // grow down with fill
        put_row(REQ_ADD,  64'd5,            63'd9,     64'd0,   64'd0,     64'd0,
                0, 1'b0, SLOT_NONE, ST_OK, 64'd0);          // fill an empty entry
        put_row(REQ_TAKE, 64'd0,            63'd0,     64'd9,   64'd0,     64'd3,
                0, 1'b0, SLOT_NONE, ST_OK, 64'd0);          // take behind the head

        // Hold reset, then release it on a falling edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < dir_rows.size(); k++)
            send_beat(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);

        // Random part: mostly beats near the live window so that adds grow,
        // tighten and overrun and takes find due slots; a few wide-open
        // beats flip every bit of every field.
        sim_now = 64'd0;
        for (k = 0; k < RANDOM_BEATS; k++) begin
            calm    = (k >= 350 && k < 500);
            sim_now = sim_now + 64'($urandom_range(4));
            r       = '0;
            r.req_type = ($urandom_range(99) < 55) ? REQ_ADD : REQ_TAKE;
            r.now      = sim_now + 64'($urandom_range(12)) - 64'd4;
            r.delay    = 63'($urandom_range(16));
            pick       = $urandom_range(99);
            if (pick < 6) begin
                // Reach toward the ring limit from either side.
                if ($urandom_range(1))
                    r.slot = win_lo + 64'($urandom_range(RING_DEPTH + 80));
                else
                    r.slot = win_hi - 64'($urandom_range(RING_DEPTH + 80));
            end else begin
                r.slot = win_lo + 64'($urandom_range(80)) - 64'd20;
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: r.retire_slot = win_lo + 64'($urandom_range(6)) - 64'd3;
                6, 7:             r.retire_slot = 64'd0;
                default:          r.retire_slot = rand_word();
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: r.scan_from = 64'd0;
                6, 7, 8:          r.scan_from = win_lo + 64'($urandom_range(10));
                default:          r.scan_from = rand_word();
            endcase
            if (pick >= 92) begin
                // Noise: every field drawn over its full range.
                r.slot        = rand_word();
                r.delay       = 63'(rand_word());
                r.now         = rand_word();
                r.retire_slot = rand_word();
                r.scan_from   = rand_word();
            end
            send_beat(r, 1'b0, none);
        end
        calm = 1'b0;

        @(negedge clk);
        req_if.valid <= 1'b0;

        // Drain: wait for every owed result, then give a straggler time to show.
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[slot_deadline_window_queue] OK");
        else
            $display("[slot_deadline_window_queue] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/core/sdwq_pkg.sv
rtl/core/sdwq_chan_if.sv
rtl/core/sdwq_ram.sv
rtl/core/sdwq_ctrl.sv
rtl/core/sdwq_dp.sv
rtl/core/slot_deadline_window_queue.sv
tb/sv/tb_slot_deadline_window_queue.sv
